[hw/rtl/scc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the seconds calendar counter modules.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;

    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
    localparam logic [SECOND_W-1:0] BASE_60     = 6'd60;
    localparam logic [HOUR_W:0]     HOURS_DAY   = 6'd24;
    localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_HOUR   = 3'd0,
        CFG_START_MINUTE = 3'd1,
        CFG_START_SECOND = 3'd2,
        CFG_START_DAY    = 3'd3,
        CFG_START_MONTH  = 3'd4,
        CFG_START_YEAR   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } clock_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        clock_t clock;
        date_t  date;
    } start_t;

    typedef struct packed {
        clock_t clock;
        date_t  date;
        logic   new_day;
    } result_t;

    // month lengths, no leap years
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/seconds_calendar_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_calendar_counter
// Time-of-day clock with a no-leap-year calendar.
//
// Input stream: each word is a one-second tick (load = 0) or a load
// (load = 1) that takes time and date from the start registers. Out-of-range
// start times are normalised; a time past 23:59:59 saturates there.
// Config channel: cfg_index selects start hour, minute, second, day, month,
// year (0 to 5), taken in any cycle; write only while the block is idle.
// Output stream: one word per input word with the updated hour, minute,
// second, day, month, year, and new_day set on the tick that passes midnight.
// Accepted words update the counter registers; results are registered in
// the output register or, while it is held, the skid stage. One word per
// cycle is sustained while the receiver keeps up; when it stalls, the skid
// stage takes one more word and s_axis_tready drops until the output drains.
// Reset gives 00:00:00 on day 1, month 1, year 0, start registers at the
// same values and empty output stages.
// ----------------------------------------------------------------------------
module seconds_calendar_counter
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [scc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [scc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [scc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // load
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // hour, minute, second, day, month, year, zero fill
    output logic [scc_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    output logic                                     m_axis_tuser   // new_day
);

    scc_pkg::start_t   start_reg;
    scc_pkg::clock_t   clock_next;
    scc_pkg::date_t    date_next;
    scc_pkg::result_t  result;
    scc_pkg::result_t  out_word;
    logic              accept;
    logic              load;
    logic              wrap;

    assign cfg_ready = 1'b1;
    assign load      = s_axis_tdata[0];
    assign accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg.clock      <= '0;
            start_reg.date.day   <= scc_pkg::DAY_FIRST;
            start_reg.date.month <= scc_pkg::MONTH_FIRST;
            start_reg.date.year  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scc_pkg::CFG_START_HOUR:
                    start_reg.clock.hour   <= cfg_data[scc_pkg::HOUR_W-1:0];
                scc_pkg::CFG_START_MINUTE:
                    start_reg.clock.minute <= cfg_data[scc_pkg::MINUTE_W-1:0];
                scc_pkg::CFG_START_SECOND:
                    start_reg.clock.second <= cfg_data[scc_pkg::SECOND_W-1:0];
                scc_pkg::CFG_START_DAY:
                    start_reg.date.day     <= cfg_data[scc_pkg::DAY_W-1:0];
                scc_pkg::CFG_START_MONTH:
                    start_reg.date.month   <= cfg_data[scc_pkg::MONTH_W-1:0];
                scc_pkg::CFG_START_YEAR:
                    start_reg.date.year    <= cfg_data[scc_pkg::YEAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    scc_clock u_clock
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .load       (load),
        .start      (start_reg.clock),
        .clock_next (clock_next),
        .wrap       (wrap)
    );

    scc_date u_date
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .load      (load),
        .advance   (wrap),
        .start     (start_reg.date),
        .date_next (date_next)
    );

    assign result.clock   = clock_next;
    assign result.date    = date_next;
    assign result.new_day = wrap;

    scc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {6'd0,
                           out_word.date.year,
                           out_word.date.month,
                           out_word.date.day,
                           out_word.clock.second,
                           out_word.clock.minute,
                           out_word.clock.hour};
    assign m_axis_tuser = out_word.new_day;

    // midnight rollover always shows 00:00:00
    a_new_day_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_word.new_day |->
            out_word.clock.hour == '0 && out_word.clock.minute == '0
            && out_word.clock.second == '0)
        else $error("new_day word not at midnight");

    // time fields stay normalised
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            out_word.clock.hour <= scc_pkg::HOUR_LAST
            && out_word.clock.minute <= scc_pkg::MINUTE_LAST
            && out_word.clock.second <= scc_pkg::SECOND_LAST)
        else $error("time field out of range");

    // date fields stay in range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            out_word.date.day != '0
            && out_word.date.month >= scc_pkg::MONTH_FIRST
            && out_word.date.month <= scc_pkg::MONTH_LAST)
        else $error("date field out of range");

    // input stalls only with the output stage full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule
`default_nettype wire

[hw/rtl/scc_clock.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scc_clock
// Time-of-day counter kept as hour, minute and second fields. Ticks step
// the count with carries, loads normalise and saturate the start time.
// ----------------------------------------------------------------------------
module scc_clock
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic            load,
    input  wire scc_pkg::clock_t start,
    output scc_pkg::clock_t      clock_next,
    output logic                 wrap
);

    scc_pkg::clock_t clock_reg;

    logic                           at_last;
    logic                           sec_over;
    logic                           min_over;
    logic [scc_pkg::SECOND_W-1:0]   load_second;
    logic [scc_pkg::MINUTE_W:0]     minute_sum;
    logic [scc_pkg::MINUTE_W-1:0]   load_minute;
    logic [scc_pkg::HOUR_W:0]       hour_sum;

    assign at_last = (clock_reg.hour == scc_pkg::HOUR_LAST)
                  && (clock_reg.minute == scc_pkg::MINUTE_LAST)
                  && (clock_reg.second == scc_pkg::SECOND_LAST);

    // start fields may exceed their base by less than one unit
    assign sec_over    = (start.second >= scc_pkg::BASE_60);
    assign load_second = sec_over ? (start.second - scc_pkg::BASE_60) : start.second;
    assign minute_sum  = {1'b0, start.minute} + {{scc_pkg::MINUTE_W{1'b0}}, sec_over};
    assign min_over    = (minute_sum >= {1'b0, scc_pkg::BASE_60});
    assign load_minute = min_over ? scc_pkg::MINUTE_W'(minute_sum - {1'b0, scc_pkg::BASE_60})
                                  : minute_sum[scc_pkg::MINUTE_W-1:0];
    assign hour_sum    = {1'b0, start.hour} + {{scc_pkg::HOUR_W{1'b0}}, min_over};

    always_comb
    begin
        wrap       = 1'b0;
        clock_next = clock_reg;
        if (load)
        begin
            if (hour_sum >= scc_pkg::HOURS_DAY)
            begin
                clock_next.hour   = scc_pkg::HOUR_LAST;
                clock_next.minute = scc_pkg::MINUTE_LAST;
                clock_next.second = scc_pkg::SECOND_LAST;
            end
            else
            begin
                clock_next.hour   = hour_sum[scc_pkg::HOUR_W-1:0];
                clock_next.minute = load_minute;
                clock_next.second = load_second;
            end
        end
        else if (at_last)
        begin
            clock_next = '0;
            wrap       = 1'b1;
        end
        else if (clock_reg.second != scc_pkg::SECOND_LAST)
        begin
            clock_next.second = clock_reg.second + 6'd1;
        end
        else
        begin
            clock_next.second = '0;
            if (clock_reg.minute != scc_pkg::MINUTE_LAST)
            begin
                clock_next.minute = clock_reg.minute + 6'd1;
            end
            else
            begin
                clock_next.minute = '0;
                clock_next.hour   = clock_reg.hour + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
        end
        else if (step)
        begin
            clock_reg <= clock_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/scc_date.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scc_date
// Calendar date register. Advances one day at midnight using a fixed
// month-length table, loads and clamps the start date.
// ----------------------------------------------------------------------------
module scc_date
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic            load,
    input  wire logic            advance,
    input  wire scc_pkg::date_t  start,
    output scc_pkg::date_t       date_next
);

    scc_pkg::date_t               date_reg;
    logic [scc_pkg::DAY_W-1:0]    len;

    assign len = scc_pkg::month_length(date_reg.month);

    always_comb
    begin
        date_next = date_reg;
        if (load)
        begin
            date_next.day  = (start.day == '0) ? scc_pkg::DAY_FIRST : start.day;
            if (start.month < scc_pkg::MONTH_FIRST)
            begin
                date_next.month = scc_pkg::MONTH_FIRST;
            end
            else if (start.month > scc_pkg::MONTH_LAST)
            begin
                date_next.month = scc_pkg::MONTH_LAST;
            end
            else
            begin
                date_next.month = start.month;
            end
            date_next.year = start.year;
        end
        else if (advance)
        begin
            if (date_reg.day >= len)
            begin
                date_next.day = scc_pkg::DAY_FIRST;
                if (date_reg.month >= scc_pkg::MONTH_LAST)
                begin
                    date_next.month = scc_pkg::MONTH_FIRST;
                    date_next.year  = date_reg.year + 8'd1;
                end
                else
                begin
                    date_next.month = date_reg.month + 4'd1;
                end
            end
            else
            begin
                date_next.day = date_reg.day + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.day   <= scc_pkg::DAY_FIRST;
            date_reg.month <= scc_pkg::MONTH_FIRST;
            date_reg.year  <= '0;
        end
        else if (step)
        begin
            date_reg <= date_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/scc_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scc_out_buf
// Output register with a skid stage, so a new word is taken while a
// finished one still waits for the receiver.
// ----------------------------------------------------------------------------
module scc_out_buf
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire scc_pkg::result_t in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output scc_pkg::result_t      out_word
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    scc_pkg::result_t  out_word_reg;
    scc_pkg::result_t  out_word_next;
    scc_pkg::result_t  skid_word_reg;
    scc_pkg::result_t  skid_word_next;
    logic              push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                begin
                    out_word_next = in_word;
                end
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule
`default_nettype wire
